@@ hdl/mcpg_pkg.sv @@
// mcpg_pkg: shared types, widths and octant tables for the midpoint circle point generator
// no dependencies; imported by mcpg_walker, midpoint_circle_point_generator and the testbench
package mcpg_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int CENTER_BITS    = 10;
  localparam int RADIUS_BITS    = 9;
  localparam int STEP_BITS      = 10;
  localparam int DEC_BITS       = 13;
  localparam int PIX_BITS       = 12;
  localparam int K_BITS         = 3;

  typedef enum logic [1:0] {
    MODE_FULL  = 2'd0,
    MODE_ARC1  = 2'd1,
    MODE_ARC2  = 2'd2,
    MODE_LIGHT = 2'd3
  } mode_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  // mirror of (x,y): swap the pair, then negate the first and/or second term
  typedef struct packed {
    logic swap;
    logic neg_a;
    logic neg_b;
  } oct_t;

  // one transaction worth of plotting work, handed from the walker to the emitter
  typedef struct packed {
    logic                   is_status;
    logic                   fin;
    logic [CENTER_BITS-1:0] cx;
    logic [CENTER_BITS-1:0] cy;
    mode_t                  mode;
    logic [STEP_BITS-1:0]   x0;
    logic [STEP_BITS-1:0]   y0;
    logic [STEP_BITS-1:0]   x1;
    logic [STEP_BITS-1:0]   y1;
  } job_t;

  function automatic oct_t oct_code(mode_t mode, logic [K_BITS-1:0] k);
    oct_t c;
    c = oct_t'(3'b000);
    unique case (mode)
      MODE_FULL: begin
        case (k)
          3'd1:    c = oct_t'(3'b001);
          3'd2:    c = oct_t'(3'b011);
          3'd3:    c = oct_t'(3'b111);
          3'd4:    c = oct_t'(3'b101);
          3'd5:    c = oct_t'(3'b100);
          3'd6:    c = oct_t'(3'b110);
          3'd7:    c = oct_t'(3'b010);
          default: c = oct_t'(3'b000);
        endcase
      end
      MODE_ARC1: begin
        c = (k == 3'd1) ? oct_t'(3'b100) : oct_t'(3'b000);
      end
      MODE_ARC2: begin
        case (k)
          3'd1:    c = oct_t'(3'b110);
          3'd2:    c = oct_t'(3'b010);
          default: c = oct_t'(3'b000);
        endcase
      end
      MODE_LIGHT: begin
        // second point repeats the first, third is the opposite point
        c = (k == 3'd2) ? oct_t'(3'b011) : oct_t'(3'b000);
      end
      default: c = oct_t'(3'b000);
    endcase
    return c;
  endfunction

  // index of the final mirrored point of one plot
  function automatic logic [K_BITS-1:0] plot_last_k(mode_t mode, logic x_lt_y);
    logic [K_BITS-1:0] k;
    k = '0;
    unique case (mode)
      MODE_FULL:  k = 3'd7;
      MODE_ARC1:  k = 3'd1;
      MODE_ARC2:  k = 3'd2;
      MODE_LIGHT: k = x_lt_y ? 3'd2 : 3'd0;
      default:    k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/midpoint_circle_point_generator.sv @@
// midpoint circle point generator: one start or step transaction in, mirrored points out
// each accepted transaction is held in the job register; its results leave through the output register
// a start or a finished step gives one status result; a step gives 4 to 16 points, one per cycle
// while out_stall does not hold the output register, which takes them from the job register
// reset clears the circle state, the job busy flag and the output valid; no init pass
// depends on mcpg_pkg and mcpg_walker
module midpoint_circle_point_generator import mcpg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [CENTER_BITS-1:0]     center_x,
  input  logic [CENTER_BITS-1:0]     center_y,
  input  logic [RADIUS_BITS-1:0]     radius,
  input  logic [1:0]                 sym_mode,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       point_valid,
  output logic signed [PIX_BITS-1:0] px,
  output logic signed [PIX_BITS-1:0] py,
  output logic                       last,
  output logic                       finished
);

  job_t              job_load;
  job_t              job;
  logic              job_busy;
  logic              job_phase;
  logic [K_BITS-1:0] job_k;

  logic                 accept;
  logic                 move;
  logic                 job_last;
  logic [STEP_BITS-1:0] cur_x;
  logic [STEP_BITS-1:0] cur_y;
  logic [K_BITS-1:0]    k_last;
  oct_t                 oct;
  logic [PIX_BITS-1:0]  term_a;
  logic [PIX_BITS-1:0]  term_b;
  logic [PIX_BITS-1:0]  pt_x;
  logic [PIX_BITS-1:0]  pt_y;

  mcpg_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .func     (func),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .sym_mode (sym_mode),
    .job_load (job_load)
  );

  always_comb begin
    cur_x  = job_phase ? job.x1 : job.x0;
    cur_y  = job_phase ? job.y1 : job.y0;
    k_last = plot_last_k(job.mode, cur_x < cur_y);
    oct    = oct_code(job.mode, job_k);
    term_a = PIX_BITS'(oct.swap ? cur_y : cur_x);
    term_b = PIX_BITS'(oct.swap ? cur_x : cur_y);
    if (oct.neg_a) begin
      term_a = -term_a;
    end
    if (oct.neg_b) begin
      term_b = -term_b;
    end
    pt_x     = PIX_BITS'(job.cx) + term_a;
    pt_y     = PIX_BITS'(job.cy) + term_b;
    job_last = job.is_status || (job_phase && (job_k == k_last));
  end

  // a new transaction enters as the last point of the previous one leaves
  assign move     = job_busy && (!out_valid || !out_stall);
  assign in_stall = job_busy && !(move && job_last);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_busy  <= 1'b0;
      job_phase <= 1'b0;
      job_k     <= '0;
    end else if (accept) begin
      job_busy  <= 1'b1;
      job_phase <= 1'b0;
      job_k     <= '0;
    end else if (move) begin
      if (job_last) begin
        job_busy <= 1'b0;
      end else if (job_k == k_last) begin
        job_phase <= 1'b1;
        job_k     <= '0;
      end else begin
        job_k <= job_k + K_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      point_valid <= !job.is_status;
      px          <= job.is_status ? '0 : pt_x;
      py          <= job.is_status ? '0 : pt_y;
      last        <= job_last;
      finished    <= job.fin;
    end
  end

  a_stall_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (job_busy && out_valid && out_stall) |-> in_stall)
    else $error("input taken while the job register cannot drain");

  a_accept_loads_job: assert property (@(posedge clk) disable iff (rst)
    accept |=> job_busy)
    else $error("accepted transaction did not load the job register");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !point_valid) |-> (px == '0 && py == '0 && last))
    else $error("status result carries a point or is not last");

  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    (job_busy && !job.is_status) |-> (job_k <= k_last))
    else $error("mirror index past the end of the plot");

  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (move && job_last && !accept) |=> !job_busy)
    else $error("job register stayed busy after its last point");

endmodule

@@ hdl/mcpg_walker.sv @@
// mcpg_walker: circle state (center, mode, octant walker, decision) and one midpoint iteration
// depends on mcpg_pkg; produces the job record loaded by the top level on each transaction
module mcpg_walker import mcpg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   func,
  input  logic [CENTER_BITS-1:0] center_x,
  input  logic [CENTER_BITS-1:0] center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic [1:0]             sym_mode,
  output job_t                   job_load
);

  localparam int CW = (COORD_BITS < CENTER_BITS) ? COORD_BITS : CENTER_BITS;
  localparam int RW = (COORD_BITS - 1 < RADIUS_BITS) ? COORD_BITS - 1 : RADIUS_BITS;
  localparam logic [RADIUS_BITS-1:0] RAD_MASK = RADIUS_BITS'((1 << RW) - 1);

  logic [CW-1:0]        cur_center_x, cur_center_x_next;
  logic [CW-1:0]        cur_center_y, cur_center_y_next;
  logic [STEP_BITS-1:0] step_x, step_x_next;
  logic [STEP_BITS-1:0] step_y, step_y_next;
  logic [DEC_BITS-1:0]  decision, decision_next;
  mode_t                cur_mode, cur_mode_next;

  logic [RADIUS_BITS-1:0] rad;
  logic [STEP_BITS-1:0]   rad_step;
  logic                   active;
  logic                   dec_neg;
  logic [DEC_BITS-1:0]    dec_inc;
  logic [STEP_BITS-1:0]   x_iter;
  logic [STEP_BITS-1:0]   y_iter;

  always_comb begin
    rad      = radius & RAD_MASK;
    rad_step = STEP_BITS'(rad);
    active   = step_y > step_x;
    dec_neg  = decision[DEC_BITS-1];
    if (dec_neg) begin
      dec_inc = (DEC_BITS'(step_x) << 1) + DEC_BITS'(3);
    end else begin
      dec_inc = ((DEC_BITS'(step_x) - DEC_BITS'(step_y)) << 1) + DEC_BITS'(5);
    end
    x_iter = step_x + STEP_BITS'(1);
    y_iter = dec_neg ? step_y : step_y - STEP_BITS'(1);

    cur_center_x_next = cur_center_x;
    cur_center_y_next = cur_center_y;
    step_x_next       = step_x;
    step_y_next       = step_y;
    decision_next     = decision;
    cur_mode_next     = cur_mode;

    job_load           = '0;
    job_load.is_status = 1'b1;
    job_load.fin       = 1'b1;

    if (func_t'(func) == FUNC_START) begin
      cur_center_x_next = center_x[CW-1:0];
      cur_center_y_next = center_y[CW-1:0];
      cur_mode_next     = mode_t'(sym_mode);
      step_x_next       = '0;
      step_y_next       = rad_step;
      decision_next     = DEC_BITS'(1) - DEC_BITS'(rad);
      job_load.fin      = (rad == '0);
    end else if (active) begin
      step_x_next        = x_iter;
      step_y_next        = y_iter;
      decision_next      = decision + dec_inc;
      job_load.is_status = 1'b0;
      job_load.fin       = !(y_iter > x_iter);
      job_load.cx        = CENTER_BITS'(cur_center_x);
      job_load.cy        = CENTER_BITS'(cur_center_y);
      job_load.mode      = cur_mode;
      job_load.x0        = step_x;
      job_load.y0        = step_y;
      job_load.x1        = x_iter;
      job_load.y1        = y_iter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_center_x <= '0;
      cur_center_y <= '0;
      step_x       <= '0;
      step_y       <= '0;
      decision     <= '0;
      cur_mode     <= MODE_FULL;
    end else if (accept) begin
      cur_center_x <= cur_center_x_next;
      cur_center_y <= cur_center_y_next;
      step_x       <= step_x_next;
      step_y       <= step_y_next;
      decision     <= decision_next;
      cur_mode     <= cur_mode_next;
    end
  end

endmodule

@@ tb/tb_midpoint_circle_point_generator.sv @@
`timescale 1ns / 100ps
// tb_midpoint_circle_point_generator: self-checking testbench, directed table then random circles
// depends on mcpg_pkg and midpoint_circle_point_generator
module tb_midpoint_circle_point_generator import mcpg_pkg::*; ();

  typedef struct {
    logic                       pv;
    logic signed [PIX_BITS-1:0] x;
    logic signed [PIX_BITS-1:0] y;
    logic                       lst;
    logic                       fin;
  } point_t;

  typedef struct {
    func_t                  f;
    logic [CENTER_BITS-1:0] cx;
    logic [CENTER_BITS-1:0] cy;
    logic [RADIUS_BITS-1:0] r;
    mode_t                  m;
    logic                   typed;
    logic                   fin;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic [CENTER_BITS-1:0] center_x = '0;
  logic [CENTER_BITS-1:0] center_y = '0;
  logic [RADIUS_BITS-1:0] radius = '0;
  logic [1:0] sym_mode = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic point_valid;
  logic signed [PIX_BITS-1:0] px;
  logic signed [PIX_BITS-1:0] py;
  logic last;
  logic finished;

  // circle walker state as the block should hold it
  logic [CENTER_BITS-1:0] circ_cx = '0;
  logic [CENTER_BITS-1:0] circ_cy = '0;
  logic [STEP_BITS-1:0]   walk_x = '0;
  logic [STEP_BITS-1:0]   walk_y = '0;
  logic [DEC_BITS-1:0]    circ_dec = '0;
  mode_t                  circ_mode = MODE_FULL;

  point_t    plot_buf[$];
  point_t    point_q[$];
  stim_row_t dir_rows[$];
  int        errors = 0;
  int        sent = 0;
  logic      quiet = 1'b0;
  logic      hold_req = 1'b0;

  midpoint_circle_point_generator uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .sym_mode   (sym_mode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .point_valid(point_valid),
    .px         (px),
    .py         (py),
    .last       (last),
    .finished   (finished)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic add_point(int dx, int dy);
    point_t p;
    p.pv  = 1'b1;
    p.x   = PIX_BITS'(int'(circ_cx) + dx);
    p.y   = PIX_BITS'(int'(circ_cy) + dy);
    p.lst = 1'b0;
    p.fin = 1'b0;
    plot_buf.push_back(p);
  endtask

  task automatic plot_octants(int x, int y);
    add_point(x, y);
    case (circ_mode)
      MODE_FULL: begin
        add_point(x, -y);
        add_point(-x, -y);
        add_point(-y, -x);
        add_point(y, -x);
        add_point(y, x);
        add_point(-y, x);
        add_point(-x, y);
      end
      MODE_ARC1: add_point(y, x);
      MODE_ARC2: begin
        add_point(-y, x);
        add_point(-x, y);
      end
      default: begin
        // light mode keeps the repeated point
        if (x < y) begin
          add_point(x, y);
          add_point(-x, -y);
        end
      end
    endcase
  endtask

  task automatic add_status(logic fin);
    point_t p;
    p.pv  = 1'b0;
    p.x   = '0;
    p.y   = '0;
    p.lst = 1'b1;
    p.fin = fin;
    plot_buf.push_back(p);
  endtask

  // advance the circle walker by one transaction, leaving its points in plot_buf
  task automatic walk_circle(func_t f, logic [CENTER_BITS-1:0] cx, logic [CENTER_BITS-1:0] cy,
                             logic [RADIUS_BITS-1:0] r, mode_t m);
    int x;
    int y;
    int d;
    plot_buf.delete();
    if (f == FUNC_START) begin
      circ_cx   = cx;
      circ_cy   = cy;
      circ_mode = m;
      walk_x    = '0;
      walk_y    = STEP_BITS'(r);
      circ_dec  = DEC_BITS'(1 - int'(r));
      add_status(walk_y == '0);
    end else if (!(walk_y > walk_x)) begin
      add_status(1'b1);
    end else begin
      x = walk_x;
      y = walk_y;
      plot_octants(x, y);
      d = $signed(circ_dec);
      if (d < 0) begin
        d = d + 2 * x + 3;
      end else begin
        d = d + 2 * (x - y) + 5;
        y = y - 1;
      end
      x = x + 1;
      circ_dec = DEC_BITS'(d);
      walk_x   = STEP_BITS'(x);
      walk_y   = STEP_BITS'(y);
      plot_octants(x, y);
      foreach (plot_buf[i]) plot_buf[i].fin = !(walk_y > walk_x);
      plot_buf[plot_buf.size() - 1].lst = 1'b1;
    end
  endtask

  task automatic add_row(func_t f, int cx, int cy, int r, mode_t m, logic typed, logic fin);
    stim_row_t s;
    s.f     = f;
    s.cx    = CENTER_BITS'(cx);
    s.cy    = CENTER_BITS'(cy);
    s.r     = RADIUS_BITS'(r);
    s.m     = m;
    s.typed = typed;
    s.fin   = fin;
    dir_rows.push_back(s);
  endtask

  // offer one transaction, wait for it to be taken, then queue what it should produce
  task automatic send_item(stim_row_t s);
    point_t p;
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= s.f;
    center_x <= s.cx;
    center_y <= s.cy;
    radius   <= s.r;
    sym_mode <= s.m;
    do @(posedge clk); while (in_stall);
    sent++;
    walk_circle(s.f, s.cx, s.cy, s.r, s.m);
    if (s.typed) begin
      p.pv  = 1'b0;
      p.x   = '0;
      p.y   = '0;
      p.lst = 1'b1;
      p.fin = s.fin;
      point_q.push_back(p);
    end else begin
      foreach (plot_buf[i]) point_q.push_back(plot_buf[i]);
    end
  endtask

  task automatic send_random(func_t f, int r);
    stim_row_t s;
    s.f     = f;
    s.cx    = CENTER_BITS'($urandom);
    s.cy    = CENTER_BITS'($urandom);
    s.r     = RADIUS_BITS'(r);
    s.m     = mode_t'($urandom_range(3));
    s.typed = 1'b0;
    s.fin   = 1'b0;
    send_item(s);
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    do @(posedge clk); while (point_q.size() != 0);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    point_t want;
    if (!rst && out_valid && !out_stall) begin
      if (point_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual pv=%0d px=%0d py=%0d",
                 $time, point_valid, px, py);
      end else begin
        want = point_q.pop_front();
        check_field("point_valid", want.pv, point_valid);
        check_field("px", int'(want.x), int'(px));
        check_field("py", int'(want.y), int'(py));
        check_field("last", want.lst, last);
        check_field("finished", want.fin, finished);
      end
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 13);
      end
    end
  end

  initial begin
    int   cut;
    int   n;
    int   r;
    int   sel;
    logic held;
    logic paused;
    held   = 1'b0;
    paused = 1'b0;

    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b1, 1'b1);
    add_row(FUNC_START, 0, 0, 0, MODE_FULL, 1'b1, 1'b1);
    add_row(FUNC_STEP, 1023, 1023, 511, MODE_LIGHT, 1'b1, 1'b1);
    add_row(FUNC_START, 1023, 1023, 511, MODE_FULL, 1'b1, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 1023, 0, 511, MODE_ARC2, 1'b0, 1'b0);
    add_row(FUNC_START, 0, 0, 511, MODE_ARC1, 1'b1, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_START, 512, 0, 1, MODE_ARC2, 1'b1, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b1, 1'b1);
    add_row(FUNC_START, 5, 1020, 2, MODE_LIGHT, 1'b1, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b1, 1'b1);
    // radius 3 in light mode lands on x equal to y
    add_row(FUNC_START, 100, 200, 3, MODE_LIGHT, 1'b1, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b1, 1'b1);
    add_row(FUNC_START, 1023, 0, 7, MODE_FULL, 1'b1, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);
    add_row(FUNC_STEP, 0, 0, 0, MODE_FULL, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    while (sent < 420) begin
      quiet = (sent >= 200 && sent < 280);
      if (!held && sent >= 100) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && sent >= 300) begin
        drain_points();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 5) begin
        send_random(func_t'($urandom_range(1)), $urandom_range(511));
      end else begin
        sel = $urandom_range(99);
        if (sel < 70) r = $urandom_range(1, 16);
        else if (sel < 90) r = $urandom_range(17, 64);
        else r = $urandom_range(0, 511);
        // some circles are abandoned part way through
        cut = ($urandom_range(99) < 20) ? $urandom_range(0, 8) : 64;
        send_random(FUNC_START, r);
        n = 0;
        while (n < cut && walk_y > walk_x && sent < 420) begin
          send_random(FUNC_STEP, $urandom_range(511));
          n++;
        end
        repeat ($urandom_range(0, 2)) send_random(FUNC_STEP, $urandom_range(511));
      end
    end

    drain_points();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_midpoint_circle_point_generator: done, clean");
    end else begin
      $display("tb_midpoint_circle_point_generator: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_midpoint_circle_point_generator: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mcpg_pkg.sv
hdl/mcpg_walker.sv
hdl/midpoint_circle_point_generator.sv
tb/tb_midpoint_circle_point_generator.sv
